>>> rtl/cmpp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and mode decoding for the charger mode pulse programmer.
package cmpp_pkg;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_USB100  = 3'd1,
    MODE_USB500  = 3'd2,
    MODE_ISET    = 3'd3,
    MODE_FACTORY = 3'd4,
    MODE_UNKNOWN = 3'd5
  } mode_e;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_OFF   = 6'b000010,
    PH_SETUP = 6'b000100,
    PH_PULSE = 6'b001000,
    PH_GAP   = 6'b010000,
    PH_FINAL = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    CFG_SETUP = 2'd0,
    CFG_PULSE = 2'd1,
    CFG_HOLD  = 2'd2
  } cfg_idx_e;

  localparam int unsigned SetupW = 16;
  localparam int unsigned PulseW = 10;
  localparam int unsigned HoldW  = 12;
  localparam int unsigned TimerW = 16;

  localparam logic [SetupW-1:0] SetupReset = 16'd35000;
  localparam logic [PulseW-1:0] PulseReset = 10'd150;
  localparam logic [HoldW-1:0]  HoldReset  = 12'd1800;

  typedef struct packed {
    logic [SetupW-1:0] setup_ticks;
    logic [PulseW-1:0] pulse_ticks;
    logic [HoldW-1:0]  hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic rejected;
  } res_t;

  function automatic logic is_pulse_mode(mode_e m);
    return (m == MODE_USB100) || (m == MODE_USB500) || (m == MODE_ISET) ||
           (m == MODE_FACTORY);
  endfunction

  function automatic logic [1:0] pulse_count(mode_e m);
    logic [1:0] n;
    case (m)
      MODE_USB100:  n = 2'd2;
      MODE_ISET:    n = 2'd1;
      MODE_FACTORY: n = 2'd3;
      default:      n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/cmpp_seq.sv
`timescale 1ns / 1ps
// Pulse sequencer state and the next-state logic for one request or tick.
module cmpp_seq import cmpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       kind_i,
  input  logic [2:0] mode_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  typedef struct packed {
    phase_e            phase;
    logic [1:0]        pulses;
    logic              pin;
    logic [TimerW-1:0] rem;
  } seq_t;

  // Walks forward from phase p past every phase whose length is zero.
  function automatic seq_t settle(phase_e p, logic [1:0] pl, mode_e pend, logic pin,
                                  cfg_t c);
    seq_t s;
    s.phase  = p;
    s.pulses = pl;
    s.pin    = pin;
    s.rem    = '0;
    if (s.phase == PH_OFF) begin
      s.pin = 1'b1;
      if (c.hold_ticks != '0) begin
        s.rem = {{(TimerW-HoldW){1'b0}}, c.hold_ticks};
      end else if (is_pulse_mode(pend)) begin
        s.pulses = pulse_count(pend);
        s.phase  = PH_SETUP;
      end else begin
        s.phase = PH_IDLE;
      end
    end
    if (s.phase == PH_SETUP) begin
      s.pin = 1'b0;
      if (c.setup_ticks != '0) begin
        s.rem = c.setup_ticks;
      end else begin
        s.phase = (s.pulses != 2'd0) ? PH_PULSE : PH_FINAL;
      end
    end
    if (s.phase == PH_GAP) begin
      s.pin = 1'b0;
      if (c.pulse_ticks != '0) begin
        s.rem = {{(TimerW-PulseW){1'b0}}, c.pulse_ticks};
      end else begin
        s.phase = PH_PULSE;
      end
    end
    if (s.phase == PH_PULSE) begin
      s.pin = 1'b1;
      if (c.pulse_ticks != '0) begin
        s.rem = {{(TimerW-PulseW){1'b0}}, c.pulse_ticks};
      end else begin
        s.pulses = 2'd0;
        s.phase  = PH_FINAL;
      end
    end
    if (s.phase == PH_FINAL) begin
      s.pin = 1'b0;
      if (c.hold_ticks != '0) begin
        s.rem = {{(TimerW-HoldW){1'b0}}, c.hold_ticks};
      end else begin
        s.phase = PH_IDLE;
      end
    end
    return s;
  endfunction

  mode_e             cur_mode_q, cur_mode_d;
  mode_e             pend_mode_q, pend_mode_d;
  phase_e            phase_q, phase_d;
  logic [TimerW-1:0] rem_q, rem_d;
  logic [1:0]        pulses_q, pulses_d;
  logic              pin_q, pin_d;
  mode_e             mode;
  logic              busy;
  logic              rej;
  phase_e            nxt_phase;
  logic [1:0]        nxt_pulses;
  seq_t              st;

  assign mode = (mode_i > MODE_UNKNOWN) ? MODE_UNKNOWN : mode_e'(mode_i);
  assign busy = (phase_q != PH_IDLE);

  always_comb begin
    nxt_phase  = PH_IDLE;
    nxt_pulses = pulses_q;
    case (phase_q)
      PH_OFF: begin
        if (is_pulse_mode(pend_mode_q)) begin
          nxt_pulses = pulse_count(pend_mode_q);
          nxt_phase  = PH_SETUP;
        end
      end
      PH_SETUP: nxt_phase = (pulses_q != 2'd0) ? PH_PULSE : PH_FINAL;
      PH_PULSE: begin
        nxt_pulses = pulses_q - 2'd1;
        nxt_phase  = (nxt_pulses != 2'd0) ? PH_GAP : PH_FINAL;
      end
      PH_GAP:   nxt_phase = PH_PULSE;
      default:  nxt_phase = PH_IDLE;
    endcase
  end

  always_comb begin
    cur_mode_d  = cur_mode_q;
    pend_mode_d = pend_mode_q;
    phase_d     = phase_q;
    rem_d       = rem_q;
    pulses_d    = pulses_q;
    pin_d       = pin_q;
    rej         = 1'b0;
    st          = settle(nxt_phase, nxt_pulses, pend_mode_q, pin_q, cfg_i);
    if (!kind_i) begin
      if (busy) begin
        rej = 1'b1;
      end else if (mode != cur_mode_q) begin
        cur_mode_d  = mode;
        pend_mode_d = mode;
        if ((mode == MODE_OFF) || (cur_mode_q != MODE_OFF)) begin
          st       = settle(PH_OFF, pulses_q, mode, pin_q, cfg_i);
          phase_d  = st.phase;
          rem_d    = st.rem;
          pulses_d = st.pulses;
          pin_d    = st.pin;
        end else if (is_pulse_mode(mode)) begin
          st       = settle(PH_SETUP, pulse_count(mode), mode, pin_q, cfg_i);
          phase_d  = st.phase;
          rem_d    = st.rem;
          pulses_d = st.pulses;
          pin_d    = st.pin;
        end
      end
    end else if (busy) begin
      if (rem_q > {{(TimerW-1){1'b0}}, 1'b1}) begin
        rem_d = rem_q - {{(TimerW-1){1'b0}}, 1'b1};
      end else begin
        phase_d  = st.phase;
        rem_d    = st.rem;
        pulses_d = st.pulses;
        pin_d    = st.pin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode_q  <= MODE_UNKNOWN;
      pend_mode_q <= MODE_UNKNOWN;
      phase_q     <= PH_IDLE;
      rem_q       <= '0;
      pulses_q    <= 2'd0;
      pin_q       <= 1'b1;
    end else if (en_i) begin
      cur_mode_q  <= cur_mode_d;
      pend_mode_q <= pend_mode_d;
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      pulses_q    <= pulses_d;
      pin_q       <= pin_d;
    end
  end

  assign res_o.pin_level = pin_d;
  assign res_o.busy_res  = (phase_d != PH_IDLE);
  assign res_o.rejected  = rej;

endmodule

>>> rtl/charger_mode_pulse_programmer_core.sv
`timescale 1ns / 1ps
// Top level of the charger mode pulse programmer: request stage, sequencer, result register.
// An accepted request waits in the request stage; the result register loads when it advances.
// Throughput: one request or tick per cycle if not stalled; each is one sequencer pass.
// Reset: sequencer pin high, mode unknown, sequencer idle, timing registers at their defaults.
// The block takes requests as soon as reset is released.
module charger_mode_pulse_programmer_core import cmpp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [2:0]        mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              pin_level_o,
  output logic              busy_res_o,
  output logic              rejected_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [SetupW-1:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  logic       s_valid_q;
  logic       s_kind_q;
  logic [2:0] s_mode_q;
  logic       out_valid_q;
  res_t       res_q;
  res_t       res;
  logic       adv;
  logic       in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setup_ticks <= SetupReset;
      cfg_q.pulse_ticks <= PulseReset;
      cfg_q.hold_ticks  <= HoldReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SETUP: cfg_q.setup_ticks <= cfg_wdata_i;
        CFG_PULSE: cfg_q.pulse_ticks <= cfg_wdata_i[PulseW-1:0];
        CFG_HOLD:  cfg_q.hold_ticks  <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = s_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s_valid_q <= 1'b1;
      end else if (adv) begin
        s_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_kind_q <= kind_i;
      s_mode_q <= mode_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  cmpp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .kind_i (s_kind_q),
    .mode_i (s_mode_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign pin_level_o = res_q.pin_level;
  assign busy_res_o  = res_q.busy_res;
  assign rejected_o  = res_q.rejected;

endmodule

>>> rtl/cmpp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the charger mode pulse programmer and its bind to the top level.
module cmpp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic pin_level_o,
  input logic busy_res_o,
  input logic rejected_o
);

  // A rejected request changes nothing, so the sequence it collided with is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o)
    else $error("rejected request reported while not busy");

  // With the result register empty, the request stage always drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the result register is empty");

  // Every accepted request shows up at the result port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("accepted request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pin_level_o) &&
    $stable(busy_res_o) && $stable(rejected_o))
    else $error("stalled result changed");

endmodule

bind charger_mode_pulse_programmer_core cmpp_checker u_cmpp_checker (.*);
